// File: hw/rtl/dq_pkg.sv
// Shared constants, command and status codes, the controller state type and the
// controller-to-datapath command struct of the double-ended queue.
// Depends on nothing; every other file of the block imports it.
package dq_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int CMD_W      = 3;
   localparam int STAT_W     = 2;

   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd4;

   localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_LOOK,
      S_REPORT
   } state_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic look;
   } dq_ctl_type;

   function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] idx);
      return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + IDX_W'(1);
   endfunction

   function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] idx);
      return (idx == '0) ? IDX_W'(DEPTH - 1) : idx - IDX_W'(1);
   endfunction

endpackage

// File: hw/rtl/dq_ctrl.sv
// Controller state machine of the double-ended queue: sequences one request through
// load, execute, lookup and report. Depends on dq_pkg.
module dq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   output logic               rsp_valid,
   output dq_pkg::dq_ctl_type ctl
);
   import dq_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC:   state_in = S_LOOK;
         S_LOOK:   state_in = S_REPORT;
         S_REPORT: state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      ctl       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            busy     = 1'b0;
            ctl.load = start;
         end
         S_EXEC:   ctl.exec = 1'b1;
         S_LOOK:   ctl.look = 1'b1;
         S_REPORT: begin
            rsp_valid  = 1'b1;
         end
         default:  busy = 1'b1;
      endcase
   end

   // A result strobe always closes a request that passed through lookup.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REPORT) |-> ($past(state_ff) == S_LOOK))
      else $error("report state not preceded by lookup");

   // An accepted request keeps the block busy on the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && ctl.exec))
      else $error("accepted request did not start execution");

endmodule

// File: hw/rtl/dq_datapath.sv
// Datapath of the double-ended queue: ring memory, front and back pointers, word count
// and result registers, driven by the controller's command struct. Depends on dq_pkg.
module dq_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  dq_pkg::dq_ctl_type            ctl,
   input  logic [dq_pkg::CMD_W-1:0]      req_cmd,
   input  logic [dq_pkg::DATA_WIDTH-1:0] req_push_word,
   output logic [dq_pkg::STAT_W-1:0]     rsp_status,
   output logic [dq_pkg::DATA_WIDTH-1:0] rsp_popped_word,
   output logic [dq_pkg::DATA_WIDTH-1:0] rsp_front_word,
   output logic [dq_pkg::DATA_WIDTH-1:0] rsp_back_word,
   output logic [dq_pkg::CNT_W-1:0]      rsp_occupancy,
   output logic                          rsp_is_empty
);
   import dq_pkg::*;

   localparam int SUM_W = IDX_W + CNT_W;

   logic [DATA_WIDTH-1:0] ring_mem [DEPTH];

   logic [CMD_W-1:0]      cmd_ff;
   logic [DATA_WIDTH-1:0] word_ff;
   logic [IDX_W-1:0]      front_ff, front_in;
   logic [IDX_W-1:0]      back_ff, back_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [STAT_W-1:0]     status_ff, status_in;
   logic                  pop_ok_ff, pop_ok_in;
   logic [DATA_WIDTH-1:0] popped_ff;
   logic [DATA_WIDTH-1:0] rd_a_ff;
   logic [DATA_WIDTH-1:0] rd_b_ff;

   logic                  is_full;
   logic                  is_empty;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [IDX_W-1:0]      pop_addr;
   logic [IDX_W-1:0]      rd_a_addr;
   logic [IDX_W-1:0]      rd_b_addr;
   logic                  has_words;

   logic [SUM_W-1:0]      ring_sum;
   logic [SUM_W-1:0]      ring_wrap;

   assign is_full   = (count_ff == CNT_W'(DEPTH));
   assign is_empty  = (count_ff == '0);
   assign pop_addr  = (cmd_ff == CMD_POP_FRONT) ? front_ff : idx_prev(back_ff);
   assign rd_a_addr = ctl.exec ? pop_addr : front_ff;
   assign rd_b_addr = idx_prev(back_ff);

   always_comb begin
      front_in  = front_ff;
      back_in   = back_ff;
      count_in  = count_ff;
      status_in = status_ff;
      pop_ok_in = pop_ok_ff;
      wr_en     = 1'b0;
      wr_addr   = back_ff;
      if (ctl.exec) begin
         status_in = STAT_DONE;
         pop_ok_in = 1'b0;
         unique case (cmd_ff)
            CMD_PUSH_FRONT: begin
               if (is_full) begin
                  status_in = STAT_FULL;
               end else begin
                  front_in = idx_prev(front_ff);
                  wr_en    = 1'b1;
                  wr_addr  = idx_prev(front_ff);
                  count_in = count_ff + CNT_W'(1);
               end
            end
            CMD_PUSH_BACK: begin
               if (is_full) begin
                  status_in = STAT_FULL;
               end else begin
                  back_in  = idx_next(back_ff);
                  wr_en    = 1'b1;
                  wr_addr  = back_ff;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            CMD_POP_FRONT: begin
               if (is_empty) begin
                  status_in = STAT_EMPTY;
               end else begin
                  front_in  = idx_next(front_ff);
                  count_in  = count_ff - CNT_W'(1);
                  pop_ok_in = 1'b1;
               end
            end
            CMD_POP_BACK: begin
               if (is_empty) begin
                  status_in = STAT_EMPTY;
               end else begin
                  back_in   = idx_prev(back_ff);
                  count_in  = count_ff - CNT_W'(1);
                  pop_ok_in = 1'b1;
               end
            end
            CMD_CLEAR: begin
               front_in = '0;
               back_in  = '0;
               count_in = '0;
            end
            default: begin
               status_in = STAT_DONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         back_ff  <= '0;
         count_ff <= '0;
      end else begin
         front_ff <= front_in;
         back_ff  <= back_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      pop_ok_ff <= pop_ok_in;
      if (ctl.load) begin
         cmd_ff  <= req_cmd;
         word_ff <= req_push_word;
      end
      if (ctl.look) begin
         popped_ff <= pop_ok_ff ? rd_a_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_addr] <= word_ff;
      end
      rd_a_ff <= ring_mem[rd_a_addr];
      rd_b_ff <= ring_mem[rd_b_addr];
   end

   assign has_words       = !is_empty;
   assign rsp_status      = status_ff;
   assign rsp_popped_word = popped_ff;
   assign rsp_front_word  = has_words ? rd_a_ff : '0;
   assign rsp_back_word   = has_words ? rd_b_ff : '0;
   assign rsp_occupancy   = count_ff;
   assign rsp_is_empty    = is_empty;

   assign ring_sum  = SUM_W'(front_ff) + SUM_W'(count_ff);
   assign ring_wrap = (ring_sum >= SUM_W'(DEPTH)) ? ring_sum - SUM_W'(DEPTH) : ring_sum;

   // The back pointer always sits count words past the front pointer around the ring.
   assert property (@(posedge clock) disable iff (reset)
      IDX_W'(ring_wrap) == back_ff)
      else $error("front pointer, back pointer and count disagree");

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("word count above capacity");

   // Queue state moves only as the result of an execute cycle.
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$past(ctl.exec)) |->
         ($stable(count_ff) && $stable(front_ff) && $stable(back_ff)))
      else $error("queue state changed outside an execute cycle");

endmodule

// File: hw/rtl/double_ended_queue.sv
// Each request goes through capture, then execute (update the pointers, write the ring
// memory and issue the pop read), then lookup (read the front and back words through
// the memory's two registered read ports), then report, with rsp_valid high. busy is
// high from the cycle after start is taken until the result cycle ends, so no new
// request is taken before the last result. Each result is shown for exactly one cycle
// and cannot be held off. Top level; depends on dq_pkg, dq_ctrl and dq_datapath.
module double_ended_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [dq_pkg::CMD_W-1:0]      req_cmd,
   input  logic [dq_pkg::DATA_WIDTH-1:0] req_push_word,
   output logic                          rsp_valid,
   output logic [dq_pkg::STAT_W-1:0]     rsp_status,
   output logic [dq_pkg::DATA_WIDTH-1:0] rsp_popped_word,
   output logic [dq_pkg::DATA_WIDTH-1:0] rsp_front_word,
   output logic [dq_pkg::DATA_WIDTH-1:0] rsp_back_word,
   output logic [dq_pkg::CNT_W-1:0]      rsp_occupancy,
   output logic                          rsp_is_empty
);
   import dq_pkg::*;

   dq_ctl_type ctl;

   dq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .ctl       (ctl)
   );

   dq_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .req_cmd         (req_cmd),
      .req_push_word   (req_push_word),
      .rsp_status      (rsp_status),
      .rsp_popped_word (rsp_popped_word),
      .rsp_front_word  (rsp_front_word),
      .rsp_back_word   (rsp_back_word),
      .rsp_occupancy   (rsp_occupancy),
      .rsp_is_empty    (rsp_is_empty)
   );

endmodule
